// File: hdl/kfade_pkg.sv
// ============================================================================
// kfade_pkg: shared types and constants of the key LED fade table
// Table size, index and count widths, item and result records, action codes.
// ============================================================================
package kfade_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam logic ACT_SET  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    localparam logic [7:0]  LEVEL_OFF   = 8'h00;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    typedef struct packed {
        logic        action;
        logic [7:0]  key;
        logic [7:0]  intensity;
        logic [7:0]  decrement;
        logic [15:0] step_ticks;
    } t_item;

    typedef struct packed {
        logic       kind;
        logic       accepted;
        logic [7:0] led_key;
        logic [7:0] led_intensity;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0] used;
        logic             busy;
    } t_stat;

endpackage

// File: hdl/key_led_fade_table.sv
// ============================================================================
// key_led_fade_table: per-key LED fade table with tick-driven updates
// Stream in set and tick words; stream out set answers and LED updates.
// ============================================================================
// Each input word is either a set (tuser 0) or a tick (tuser 1). A set looks
// for its key among the used entries, else reuses the last inactive entry seen,
// else appends a new entry; it returns exactly one answer word (tuser 0,
// accepted bit 1 if stored, 0 if the table is full) with tlast high. A stored
// entry is armed to fire on the next tick. A tick walks the used entries in
// index order and returns one update word (tuser 1, key and level before the
// decrement) per firing entry, tlast on the final one; a tick with nothing to
// fire returns no word. The engine visits one table entry per cycle while the
// output side keeps up; a set stops at the entry whose key matches, and a
// tick walks all used entries of the 32-entry table. A two-word input queue
// lets the input side keep taking words while the engine walks the table,
// and the output register lets a finished word wait for tready.
// ============================================================================
module key_led_fade_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [kfade_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // key[7:0], intensity[15:8],
                                                // decrement[23:16], step_ticks[39:24]
    input  logic                                s_axis_tuser,   // action: 0 set, 1 tick
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [kfade_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // accepted[0], led_key[8:1],
                                                // led_intensity[16:9], zero[23:17]
    output logic                                m_axis_tuser,   // kind: 0 answer, 1 update
    output logic                                m_axis_tlast    // final word of this input word
);

    logic                 w_q_valid;
    logic                 w_q_pop;
    kfade_pkg::t_item     w_q_item;
    kfade_pkg::t_result   w_out;
    kfade_pkg::t_stat     w_stat;

    // front: accept and tag words, queue them for the engine
    kfade_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_user    (s_axis_tuser),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    // back: walk the table and produce answer and update words
    kfade_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (w_out),
        .o_stat      (w_stat)
    );

    // pack the result word, upper pad bits stay zero
    assign m_axis_tdata = {7'b0, w_out.led_intensity, w_out.led_key, w_out.accepted};
    assign m_axis_tuser = w_out.kind;
    assign m_axis_tlast = w_out.last;

    // a set answer is always a single, final word
    a_answer_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == kfade_pkg::KIND_ANSWER)) |-> m_axis_tlast)
        else $error("set answer without tlast");

    // LED updates never claim a stored set
    a_update_not_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == kfade_pkg::KIND_UPDATE)) |-> !m_axis_tdata[0])
        else $error("LED update with accepted bit set");

    // the used count only grows and never passes the table size
    a_used_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.used >= $past(w_stat.used)) &&
        (w_stat.used <= kfade_pkg::CNT_W'(kfade_pkg::ENTRIES)))
        else $error("entry count shrank or overflowed");

    // the engine only leaves idle after taking a queued word
    a_start_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_stat.busy && !w_q_valid) |=> !w_stat.busy)
        else $error("engine started without a queued word");

endmodule

// File: hdl/kfade_front.sv
// ============================================================================
// kfade_front: input side of the fade table
// Unpack the incoming word, tag it set or tick, and hold it in a two-deep queue.
// ============================================================================
module kfade_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [kfade_pkg::IN_TDATA_W-1:0] i_data,
    input  logic                          i_user,
    output logic                          o_q_valid,
    output kfade_pkg::t_item              o_q_item,
    input  logic                          i_q_pop
);

    kfade_pkg::t_item              r_mem [kfade_pkg::QDEPTH];
    logic [kfade_pkg::QPTR_W-1:0]  r_wptr;
    logic [kfade_pkg::QPTR_W-1:0]  r_rptr;
    logic [kfade_pkg::QCNT_W-1:0]  r_cnt;
    kfade_pkg::t_item              w_item;
    logic                          w_push;
    logic                          w_pop;

    always_comb begin
        w_item.action     = (i_user == kfade_pkg::ACT_TICK) ? kfade_pkg::ACT_TICK
                                                            : kfade_pkg::ACT_SET;
        w_item.key        = i_data[7:0];
        w_item.intensity  = i_data[15:8];
        w_item.decrement  = i_data[23:16];
        w_item.step_ticks = i_data[39:24];
    end

    assign o_ready   = (r_cnt != kfade_pkg::QCNT_W'(kfade_pkg::QDEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rptr];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_item;
        end
    end

endmodule

// File: hdl/kfade_back.sv
// ============================================================================
// kfade_back: table engine of the fade table
// Scan one entry per cycle for sets and ticks bar output stalls; send results.
// ============================================================================
module kfade_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  kfade_pkg::t_item     i_q_item,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output kfade_pkg::t_result   o_out,
    output kfade_pkg::t_stat     o_stat
);

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_SET_SCAN  = 5'b00010,
        ST_SET_DONE  = 5'b00100,
        ST_TICK_SCAN = 5'b01000,
        ST_TICK_END  = 5'b10000
    } t_state;

    // entry table
    logic [7:0]  r_key    [kfade_pkg::ENTRIES];
    logic [7:0]  r_level  [kfade_pkg::ENTRIES];
    logic [7:0]  r_dec    [kfade_pkg::ENTRIES];
    logic [15:0] r_period [kfade_pkg::ENTRIES];
    logic [15:0] r_elap   [kfade_pkg::ENTRIES];
    logic [kfade_pkg::ENTRIES-1:0] r_active;

    t_state                       r_state, n_state;
    logic [kfade_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [kfade_pkg::CNT_W-1:0]  r_used, n_used;
    logic [kfade_pkg::IDX_W-1:0]  r_pick, n_pick;
    logic                         r_pick_ok, n_pick_ok;
    kfade_pkg::t_item             r_item, n_item;
    logic                         r_hold_valid, n_hold_valid;
    logic [7:0]                   r_hold_key, n_hold_key;
    logic [7:0]                   r_hold_lvl, n_hold_lvl;
    logic                         r_out_valid, n_out_valid;
    kfade_pkg::t_result           r_out, n_out;

    logic [kfade_pkg::IDX_W-1:0]  w_idx;
    logic [7:0]                   e_key, e_level, e_dec;
    logic [15:0]                  e_period, e_elap, e_elap_inc;
    logic                         e_act, e_fires, w_scan_end, w_can_push;
    logic [7:0]                   e_level_next;

    logic                         wr_cfg, wr_dyn, act_set, act_clr;
    logic [kfade_pkg::IDX_W-1:0]  wr_idx;
    logic [7:0]                   wr_lvl;
    logic [15:0]                  wr_el;

    assign w_idx        = r_idx[kfade_pkg::IDX_W-1:0];
    assign e_key        = r_key[w_idx];
    assign e_level      = r_level[w_idx];
    assign e_dec        = r_dec[w_idx];
    assign e_period     = r_period[w_idx];
    assign e_elap       = r_elap[w_idx];
    assign e_act        = r_active[w_idx];
    assign e_elap_inc   = (e_elap == kfade_pkg::ELAPSED_MAX) ? e_elap : e_elap + 16'd1;
    assign e_fires      = (e_elap_inc >= e_period);
    assign e_level_next = (e_level <= e_dec) ? kfade_pkg::LEVEL_OFF : e_level - e_dec;
    assign w_scan_end   = (r_idx == r_used);
    assign w_can_push   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_used       = r_used;
        n_pick       = r_pick;
        n_pick_ok    = r_pick_ok;
        n_item       = r_item;
        n_hold_valid = r_hold_valid;
        n_hold_key   = r_hold_key;
        n_hold_lvl   = r_hold_lvl;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        o_q_pop      = 1'b0;
        wr_cfg       = 1'b0;
        wr_dyn       = 1'b0;
        act_set      = 1'b0;
        act_clr      = 1'b0;
        wr_idx       = w_idx;
        wr_lvl       = e_level;
        wr_el        = e_elap_inc;

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_item    = i_q_item;
                    n_idx     = '0;
                    n_pick_ok = 1'b0;
                    n_state   = (i_q_item.action == kfade_pkg::ACT_TICK) ? ST_TICK_SCAN
                                                                         : ST_SET_SCAN;
                end
            end
            ST_SET_SCAN: begin
                if (w_scan_end) begin
                    n_state = ST_SET_DONE;
                end else if (e_key == r_item.key) begin
                    // key match wins over any inactive entry seen so far
                    n_pick    = w_idx;
                    n_pick_ok = 1'b1;
                    n_state   = ST_SET_DONE;
                end else begin
                    if (!e_act) begin
                        n_pick    = w_idx;
                        n_pick_ok = 1'b1;
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_SET_DONE: begin
                if (w_can_push) begin
                    n_out_valid         = 1'b1;
                    n_out.kind          = kfade_pkg::KIND_ANSWER;
                    n_out.accepted      = 1'b0;
                    n_out.led_key       = '0;
                    n_out.led_intensity = kfade_pkg::LEVEL_OFF;
                    n_out.last          = 1'b1;
                    wr_lvl              = r_item.intensity;
                    wr_el               = r_item.step_ticks;
                    if (r_pick_ok) begin
                        wr_idx         = r_pick;
                        wr_cfg         = 1'b1;
                        wr_dyn         = 1'b1;
                        act_set        = 1'b1;
                        n_out.accepted = 1'b1;
                    end else if (r_used < kfade_pkg::CNT_W'(kfade_pkg::ENTRIES)) begin
                        // append a fresh entry
                        wr_idx         = r_used[kfade_pkg::IDX_W-1:0];
                        wr_cfg         = 1'b1;
                        wr_dyn         = 1'b1;
                        act_set        = 1'b1;
                        n_used         = r_used + 1'b1;
                        n_out.accepted = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_TICK_SCAN: begin
                if (w_scan_end) begin
                    n_state = ST_TICK_END;
                end else if (!e_act) begin
                    n_idx = r_idx + 1'b1;
                end else if (!e_fires) begin
                    wr_dyn = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end else if (!r_hold_valid || w_can_push) begin
                    // release the held update, it is not the final one
                    if (r_hold_valid) begin
                        n_out_valid         = 1'b1;
                        n_out.kind          = kfade_pkg::KIND_UPDATE;
                        n_out.accepted      = 1'b0;
                        n_out.led_key       = r_hold_key;
                        n_out.led_intensity = r_hold_lvl;
                        n_out.last          = 1'b0;
                    end
                    n_hold_valid = 1'b1;
                    n_hold_key   = e_key;
                    n_hold_lvl   = e_level;
                    wr_dyn       = 1'b1;
                    if (e_level == kfade_pkg::LEVEL_OFF) begin
                        act_clr = 1'b1;
                    end else begin
                        wr_lvl = e_level_next;
                        wr_el  = '0;
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_TICK_END: begin
                if (!r_hold_valid) begin
                    n_state = ST_IDLE;
                end else if (w_can_push) begin
                    n_out_valid         = 1'b1;
                    n_out.kind          = kfade_pkg::KIND_UPDATE;
                    n_out.accepted      = 1'b0;
                    n_out.led_key       = r_hold_key;
                    n_out.led_intensity = r_hold_lvl;
                    n_out.last          = 1'b1;
                    n_hold_valid        = 1'b0;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_used       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_active     <= '0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
            if (act_set) begin
                r_active[wr_idx] <= 1'b1;
            end else if (act_clr) begin
                r_active[wr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pick     <= n_pick;
        r_pick_ok  <= n_pick_ok;
        r_item     <= n_item;
        r_hold_key <= n_hold_key;
        r_hold_lvl <= n_hold_lvl;
        r_out      <= n_out;
        if (wr_cfg) begin
            r_key[wr_idx]    <= r_item.key;
            r_dec[wr_idx]    <= r_item.decrement;
            r_period[wr_idx] <= r_item.step_ticks;
        end
        if (wr_dyn) begin
            r_level[wr_idx] <= wr_lvl;
            r_elap[wr_idx]  <= wr_el;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_stat.used = r_used;
    assign o_stat.busy = (r_state != ST_IDLE);

endmodule

// File: tb/tb_key_led_fade_table.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_key_led_fade_table: self-checking bench for the key LED fade table
// Streams set and tick words into the table and checks every answer and LED
// update word against a cycle-free predictor of the table. The run covers a
// directed table, random traffic with both sides pacing at random, a full
// table with refused sets, and a long output stall that backs up the input.
// ============================================================================
module tb_key_led_fade_table;

    localparam int IDLE_LIMIT = 3000;   // cycles with no word moving on either side
    localparam int LONG_STALL = 400;    // output hold-off that fills the block up
    localparam int DRAIN_WAIT = 80;     // a full table walk plus margin
    localparam int RANDOM_A   = 150;
    localparam int RANDOM_B   = 220;

    // One row of the directed table. answer_known marks a set whose answer is
    // plainly "stored"; every other row is checked against the predictor.
    typedef struct {
        logic        act;
        logic [7:0]  key;
        logic [7:0]  lvl;
        logic [7:0]  dec;
        logic [15:0] per;
        bit          answer_known;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;     // key[7:0], intensity[15:8], decrement[23:16],
                                   // step_ticks[39:24]
    logic        s_axis_tuser;     // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // accepted[0], led_key[8:1], led_intensity[16:9],
                                   // zero[23:17]
    logic        m_axis_tuser;     // kind
    logic        m_axis_tlast;

    // Predictor copy of the table
    int          used_entries;
    logic        ent_on    [kfade_pkg::ENTRIES];
    logic [7:0]  ent_key   [kfade_pkg::ENTRIES];
    logic [7:0]  ent_level [kfade_pkg::ENTRIES];
    logic [7:0]  ent_dec   [kfade_pkg::ENTRIES];
    logic [15:0] ent_period[kfade_pkg::ENTRIES];
    logic [15:0] ent_count [kfade_pkg::ENTRIES];

    kfade_pkg::t_result fresh_words[$];    // words caused by the word just taken
    kfade_pkg::t_result led_words_due[$];  // words still owed by the block

    int  mismatches    = 0;
    int  words_sent    = 0;
    int  words_seen    = 0;
    int  sets_sent     = 0;
    int  ticks_sent    = 0;
    int  refused_sets  = 0;
    int  updates_due   = 0;
    int  biggest_burst = 0;
    int  idle_cycles   = 0;
    bit  tx_burst      = 1'b0;
    bit  rx_burst      = 1'b0;
    bit  fill_pace     = 1'b0;
    bit  rx_hold_req   = 1'b0;

    t_row directed_rows [22] = '{
        '{kfade_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0}, // empty table: silent
        '{kfade_pkg::ACT_SET,  8'h00, 8'h00, 8'h00, 16'h0000, 1'b1}, // all-zero set
        '{kfade_pkg::ACT_TICK, 8'h5A, 8'hA5, 8'h00, 16'h0000, 1'b0}, // emits 0, entry goes idle
        '{kfade_pkg::ACT_SET,  8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1}, // all-ones set
        '{kfade_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0}, // fires at saturated count
        '{kfade_pkg::ACT_TICK, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0}, // count restarted: silent
        '{kfade_pkg::ACT_SET,  8'h01, 8'h64, 8'h1E, 16'h0001, 1'b1}, // new key: append
        '{kfade_pkg::ACT_SET,  8'h02, 8'h0A, 8'h03, 16'h0000, 1'b1}, // no idle entry: append
        '{kfade_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0}, // two updates in one tick
        '{kfade_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{kfade_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{kfade_pkg::ACT_SET,  8'h01, 8'hC8, 8'h01, 16'h0002, 1'b1}, // refresh an active key
        '{kfade_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0}, // level saturates at zero
        '{kfade_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{kfade_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{kfade_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{kfade_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{kfade_pkg::ACT_SET,  8'h00, 8'h80, 8'h80, 16'h0000, 1'b1}, // reuse the last idle entry
        '{kfade_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{kfade_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0}, // key 0 fades out again
        '{kfade_pkg::ACT_SET,  8'h00, 8'h11, 8'h11, 16'h0005, 1'b1}, // key matches an idle entry
        '{kfade_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0}
    };

    key_led_fade_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Work out the words one input word causes and update the table copy.
    function automatic void advance_fade_table(input kfade_pkg::t_item it);
        kfade_pkg::t_result w;
        int                 pick;
        bit                 found;
        fresh_words.delete();
        if (it.action == kfade_pkg::ACT_SET) begin
            sets_sent++;
            pick  = -1;
            found = 1'b0;
            // first key match wins; otherwise remember the last idle entry
            for (int i = 0; i < used_entries && !found; i++) begin
                if (ent_key[i] == it.key) begin
                    pick  = i;
                    found = 1'b1;
                end else if (!ent_on[i]) begin
                    pick = i;
                end
            end
            if (pick < 0 && used_entries < kfade_pkg::ENTRIES) begin
                pick = used_entries;
                used_entries++;
            end
            w.kind          = kfade_pkg::KIND_ANSWER;
            w.accepted      = (pick >= 0);
            w.led_key       = '0;
            w.led_intensity = kfade_pkg::LEVEL_OFF;
            w.last          = 1'b1;
            if (pick >= 0) begin
                // arm so the entry fires on the next tick
                ent_key[pick]    = it.key;
                ent_level[pick]  = it.intensity;
                ent_dec[pick]    = it.decrement;
                ent_period[pick] = it.step_ticks;
                ent_count[pick]  = it.step_ticks;
                ent_on[pick]     = 1'b1;
            end else begin
                refused_sets++;
            end
            fresh_words.push_back(w);
        end else begin
            ticks_sent++;
            for (int i = 0; i < used_entries; i++) begin
                if (ent_on[i]) begin
                    if (ent_count[i] != kfade_pkg::ELAPSED_MAX)
                        ent_count[i] = ent_count[i] + 16'd1;
                    if (ent_count[i] >= ent_period[i]) begin
                        w.kind          = kfade_pkg::KIND_UPDATE;
                        w.accepted      = 1'b0;
                        w.led_key       = ent_key[i];
                        w.led_intensity = ent_level[i];
                        w.last          = 1'b0;
                        fresh_words.push_back(w);
                        if (ent_level[i] == kfade_pkg::LEVEL_OFF) begin
                            ent_on[i] = 1'b0;
                        end else begin
                            ent_level[i] = (ent_level[i] <= ent_dec[i]) ?
                                           kfade_pkg::LEVEL_OFF :
                                           ent_level[i] - ent_dec[i];
                            ent_count[i] = '0;
                        end
                    end
                end
            end
            if (fresh_words.size() > 0)
                fresh_words[fresh_words.size() - 1].last = 1'b1;
            updates_due += fresh_words.size();
            if (fresh_words.size() > biggest_burst)
                biggest_burst = fresh_words.size();
        end
    endfunction

    function automatic void make_random_word(output kfade_pkg::t_item it);
        int r;
        r = $urandom_range(0, 9);
        it.action     = ($urandom_range(0, 99) < 50) ? kfade_pkg::ACT_TICK
                                                     : kfade_pkg::ACT_SET;
        // a pool a bit larger than the table keeps it near full
        it.key        = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 47));
        it.intensity  = 8'($urandom);
        it.decrement  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
        if (r < 6)
            it.step_ticks = 16'($urandom_range(0, 2));
        else if (r < 9)
            it.step_ticks = 16'($urandom_range(0, 15));
        else
            it.step_ticks = 16'($urandom);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s at output word %0d: got %0h, want %0h",
                 what, words_seen, got, want);
        mismatches++;
    endtask

    // Offer one word after a random gap, hold it until taken, then predict.
    task automatic offer_word(input kfade_pkg::t_item it, input bit answer_known);
        int                 gap;
        kfade_pkg::t_result known;
        gap = (tx_burst || fill_pace) ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  = it.action;
        s_axis_tdata  = {it.step_ticks, it.decrement, it.intensity, it.key};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        advance_fade_table(it);
        if (answer_known) begin
            known.kind          = kfade_pkg::KIND_ANSWER;
            known.accepted      = 1'b1;
            known.led_key       = '0;
            known.led_intensity = kfade_pkg::LEVEL_OFF;
            known.last          = 1'b1;
            led_words_due.push_back(known);
        end else begin
            foreach (fresh_words[k]) led_words_due.push_back(fresh_words[k]);
        end
        words_sent++;
        if (words_sent % 50 == 0) tx_burst = ~tx_burst;
    endtask

    // Drop the offer, then hold off until every owed word is out.
    task automatic await_drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (led_words_due.size() != 0) @(posedge i_clk);
    endtask

    // Set every entry to a distinct key with no tick in between, so the whole
    // table ends up active; then new keys are refused and known keys refresh.
    task automatic fill_table(input bit extremes);
        kfade_pkg::t_item it;
        int               base;
        base = $urandom_range(0, 255);
        for (int k = 0; k < kfade_pkg::ENTRIES + 8; k++) begin
            it.action     = kfade_pkg::ACT_SET;
            it.key        = (k < kfade_pkg::ENTRIES + 4) ? 8'(base + k) :
                            8'(base + (k - kfade_pkg::ENTRIES) * 5);
            it.intensity  = extremes ? 8'hFF : 8'($urandom_range(1, 255));
            it.decrement  = extremes ? ((k % 2) ? 8'hFF : 8'h01) : 8'($urandom);
            it.step_ticks = extremes ? 16'h0000 : 16'($urandom_range(0, 3));
            offer_word(it, 1'b0);
        end
        // full-table ticks: up to one update per entry
        repeat (4) begin
            it.action = kfade_pkg::ACT_TICK;
            offer_word(it, 1'b0);
        end
    endtask

    initial begin : stimulus
        kfade_pkg::t_item it;
        for (int i = 0; i < kfade_pkg::ENTRIES; i++) begin
            ent_on[i]     = 1'b0;
            ent_key[i]    = '0;
            ent_level[i]  = '0;
            ent_dec[i]    = '0;
            ent_period[i] = '0;
            ent_count[i]  = '0;
        end
        used_entries  = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = kfade_pkg::ACT_SET;
        i_rst_n       = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            it.action     = directed_rows[r].act;
            it.key        = directed_rows[r].key;
            it.intensity  = directed_rows[r].lvl;
            it.decrement  = directed_rows[r].dec;
            it.step_ticks = directed_rows[r].per;
            offer_word(it, directed_rows[r].answer_known);
        end

        repeat (RANDOM_A) begin
            make_random_word(it);
            offer_word(it, 1'b0);
        end

        // Pause the input until every owed word is out, then fill the table
        // back to back while the output side holds off for a long stretch.
        await_drain();
        rx_hold_req = 1'b1;
        fill_pace   = 1'b1;
        fill_table(1'b0);
        fill_pace   = 1'b0;

        repeat (RANDOM_B) begin
            make_random_word(it);
            offer_word(it, 1'b0);
        end

        await_drain();
        fill_table(1'b1);

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        await_drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Run covered %0d sets (%0d refused) and %0d ticks, %0d output words checked.",
                 sets_sent, refused_sets, ticks_sent, words_seen);
        $display("LED updates: %0d, most in one tick: %0d.", updates_due, biggest_burst);
        if (mismatches == 0 && led_words_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Output side: random hold-off per word, plus one long stall on request.
    initial begin : receiver
        int                 wait_n;
        kfade_pkg::t_result want;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready = 1'b0;
                repeat (LONG_STALL) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            wait_n = rx_burst ? 0 : $urandom_range(0, 10);
            if (wait_n > 0) begin
                m_axis_tready = 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            words_seen++;
            if (words_seen % 40 == 0) rx_burst = ~rx_burst;
            if (led_words_due.size() == 0) begin
                report_mismatch("word with nothing owed", 32'(m_axis_tdata), '0);
            end else begin
                want = led_words_due.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
                if (m_axis_tdata[0] !== want.accepted)
                    report_mismatch("accepted", 32'(m_axis_tdata[0]), 32'(want.accepted));
                if (m_axis_tdata[8:1] !== want.led_key)
                    report_mismatch("led_key", 32'(m_axis_tdata[8:1]), 32'(want.led_key));
                if (m_axis_tdata[16:9] !== want.led_intensity)
                    report_mismatch("led_intensity", 32'(m_axis_tdata[16:9]),
                                    32'(want.led_intensity));
                if (m_axis_tdata[23:17] !== '0)
                    report_mismatch("pad bits", 32'(m_axis_tdata[23:17]), '0);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles, %0d words still owed.",
                     IDLE_LIMIT, led_words_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
